@@ sv/mbpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mbpe_pkg;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 17;
  localparam int COLOR_W = 16;
  localparam int COORD_W = 16;
  localparam int CFG_IDX_W = 2;

  // defaults handed to the top level
  localparam int SCREEN_W_DEF    = 320;
  localparam int SCREEN_H_DEF    = 240;
  localparam int QUEUE_DEPTH_DEF = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INK_COLOR = 2'd2;

  typedef enum logic [1:0] {
    PH_WIDTH  = 2'd0,
    PH_HEIGHT = 2'd1,
    PH_ROW    = 2'd2
  } phase_t;

  // one data byte after classification and clipping
  typedef struct packed {
    logic [BYTE_W-1:0]  mask;      // bit k set: column k of this byte is written
    logic [ADDR_W-1:0]  addr_base; // offset of column 0, low bits only
    logic [COLOR_W-1:0] color;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

@@ sv/mbpe_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbpe_front import mbpe_pkg::*; #(
  parameter int SCREEN_W = SCREEN_W_DEF,
  parameter int SCREEN_H = SCREEN_H_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [BYTE_W-1:0]         stream_byte,
  input  logic signed [COORD_W-1:0] origin_x,
  input  logic signed [COORD_W-1:0] origin_y,
  input  logic [COLOR_W-1:0]        ink_color,
  input  q_stat_t                   q_stat,
  output logic                      q_push,
  output job_t                      q_job
);

  // row coordinate is 17 bits signed, times the screen width, plus column
  localparam int OFF_W = COORD_W + 1 + $clog2(SCREEN_W) + 2;
  localparam logic signed [OFF_W-1:0] SCRW_S = OFF_W'(SCREEN_W);
  localparam logic signed [OFF_W-1:0] AREA_S = OFF_W'(SCREEN_W * SCREEN_H);

  phase_t      phase, phase_next;
  logic [7:0]  bitmap_width, bitmap_width_next;
  logic [7:0]  bitmap_height, bitmap_height_next;
  logic [4:0]  byte_in_row, byte_in_row_next;
  logic [7:0]  row_index, row_index_next;

  logic        accept;
  logic [5:0]  bytes_per_row;
  logic        row_end;
  logic        is_data;
  logic [3:0]  valid_cnt;
  logic [BYTE_W-1:0] set_mask;
  logic signed [COORD_W:0] py;
  logic signed [OFF_W-1:0] base;

  // stage register between classification and clipping
  logic                    s1_valid;
  logic [BYTE_W-1:0]       s1_mask;
  logic signed [OFF_W-1:0] s1_base;
  logic [COLOR_W-1:0]      s1_color;

  logic signed [OFF_W-1:0] offs [BYTE_W];
  logic [BYTE_W-1:0]       fin_mask;

  assign accept        = in_valid && !in_stall;
  assign bytes_per_row = 6'((9'(bitmap_width) + 9'd7) >> 3);
  assign row_end       = ({1'b0, byte_in_row} + 6'd1) >= bytes_per_row;

  // next state
  always_comb begin
    phase_next         = phase;
    bitmap_width_next  = bitmap_width;
    bitmap_height_next = bitmap_height;
    byte_in_row_next   = byte_in_row;
    row_index_next     = row_index;
    if (accept) begin
      case (phase)
        PH_HEIGHT: begin
          bitmap_height_next = stream_byte;
          byte_in_row_next   = '0;
          row_index_next     = '0;
          phase_next = (bitmap_width == 8'd0 || stream_byte == 8'd0) ? PH_WIDTH : PH_ROW;
        end
        PH_ROW: begin
          if (row_end) begin
            byte_in_row_next = '0;
            if ((9'(row_index) + 9'd1) >= 9'(bitmap_height)) begin
              row_index_next = '0;
              phase_next     = PH_WIDTH;
            end else begin
              row_index_next = row_index + 8'd1;
            end
          end else begin
            byte_in_row_next = byte_in_row + 5'd1;
          end
        end
        default: begin
          bitmap_width_next = stream_byte;
          phase_next        = PH_HEIGHT;
        end
      endcase
    end
  end

  // outputs: which bits count and where column 0 of this byte lands
  always_comb begin
    is_data   = (phase == PH_ROW);
    valid_cnt = (row_end && bitmap_width[2:0] != 3'd0) ? {1'b0, bitmap_width[2:0]} : 4'd8;
    for (int k = 0; k < BYTE_W; k++) begin
      set_mask[k] = stream_byte[BYTE_W-1-k] && (4'(k) < valid_cnt);
    end
    py   = $signed({origin_y[COORD_W-1], origin_y}) + $signed({9'b0, row_index});
    base = OFF_W'(py) * SCRW_S + OFF_W'(origin_x)
         + $signed(OFF_W'({byte_in_row, 3'b000}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WIDTH;
      bitmap_width  <= '0;
      bitmap_height <= '0;
      byte_in_row   <= '0;
      row_index     <= '0;
    end else begin
      phase         <= phase_next;
      bitmap_width  <= bitmap_width_next;
      bitmap_height <= bitmap_height_next;
      byte_in_row   <= byte_in_row_next;
      row_index     <= row_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= accept && is_data && (|set_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_stall) begin
      s1_mask  <= set_mask;
      s1_base  <= base;
      s1_color <= ink_color;
    end
  end

  // clip: each column's linear offset must land inside the screen
  always_comb begin
    for (int k = 0; k < BYTE_W; k++) begin
      offs[k]     = s1_base + $signed(OFF_W'(k));
      fin_mask[k] = s1_mask[k] && (offs[k] >= 0) && (offs[k] < AREA_S);
    end
  end

  assign in_stall        = s1_valid && (|fin_mask) && q_stat.full;
  assign q_push          = s1_valid && (|fin_mask) && !q_stat.full;
  assign q_job.mask      = fin_mask;
  assign q_job.addr_base = s1_base[ADDR_W-1:0];
  assign q_job.color     = s1_color;

endmodule

`default_nettype wire

@@ sv/mbpe_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbpe_fifo import mbpe_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    wr_job,
  input  logic    pop,
  output job_t    rd_job,
  output q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign rd_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/mbpe_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbpe_back import mbpe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  job_t               q_head,
  input  q_stat_t            q_stat,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  pixel_address,
  output logic [COLOR_W-1:0] pixel_color,
  output logic               run_last
);

  logic [BYTE_W-1:0]  cur_mask;
  logic [ADDR_W-1:0]  cur_base;
  logic [COLOR_W-1:0] cur_color;

  logic               advance;
  logic               cur_active;
  logic               emit;
  logic [2:0]         col;
  logic [BYTE_W-1:0]  rest;

  // lowest remaining column first
  always_comb begin
    col = '0;
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      if (cur_mask[k]) begin
        col = 3'(k);
      end
    end
    rest = cur_mask & ~(BYTE_W'(1) << col);
  end

  assign advance    = !out_valid || !out_stall;
  assign cur_active = |cur_mask;
  assign emit       = advance && cur_active;
  assign q_pop      = !q_stat.empty && (!cur_active || (emit && rest == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_mask <= q_head.mask;
      end else if (emit) begin
        cur_mask <= rest;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (advance) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_base  <= q_head.addr_base;
      cur_color <= q_head.color;
    end
    if (emit) begin
      pixel_address <= cur_base + ADDR_W'(col);
      pixel_color   <= cur_color;
      run_last      <= (rest == '0);
    end
  end

endmodule

`default_nettype wire

@@ sv/mono_bitmap_pixel_expander.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------------
// input     | in_valid / in_stall    | stream_byte
// output    | out_valid / out_stall  | pixel_address, pixel_color, run_last
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one input word is taken per cycle while the job queue has room; header words
// and data words with no visible pixel leave nothing in the queue
// the pixel unit emits one write per cycle while out_stall is low, one write per
// set, on-screen column of a data word, and the output port sets the rate
// a data word passes stage register, queue and job register to the output register
// rst is synchronous and clears the header state, queue and output valid
// out_stall holds the output register; the queue then fills and in_stall rises

module mono_bitmap_pixel_expander import mbpe_pkg::*; #(
  parameter int SCREEN_W    = SCREEN_W_DEF,
  parameter int SCREEN_H    = SCREEN_H_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // bitmap byte stream
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    stream_byte,
  // framebuffer writes
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    pixel_address,
  output logic [COLOR_W-1:0]   pixel_color,
  output logic                 run_last,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  // configuration registers
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic [COLOR_W-1:0]        ink_color;

  // front to queue to back
  logic    q_push;
  logic    q_pop;
  job_t    q_in;
  job_t    q_head;
  q_stat_t q_stat;

  // writes are always taken; an unknown index is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      ink_color <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X:  origin_x  <= $signed(cfg_data);
        CFG_ORIGIN_Y:  origin_y  <= $signed(cfg_data);
        CFG_INK_COLOR: ink_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // header parsing, row/column tracking, offset and clipping
  mbpe_front #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stream_byte (stream_byte),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .ink_color   (ink_color),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_job       (q_in)
  );

  // short job queue decouples word intake from pixel output
  mbpe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (q_in),
    .pop    (q_pop),
    .rd_job (q_head),
    .stat   (q_stat)
  );

  // walks each job's column mask, one write per cycle while out_stall is low
  mbpe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .run_last      (run_last)
  );

  // the front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  // the back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // writes of one word leave back to back until the last one
  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !run_last) |=> out_valid)
    else $error("gap inside a word's pixel burst");

  // reset leaves both channels quiet
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("channel active after reset");

endmodule

`default_nettype wire
